### src/udpd_pkg.sv
// ----------------------------------------------------------------------------
// udpd_pkg
// Shared types and constants for the UDP port demultiplexer.
// ----------------------------------------------------------------------------
package udpd_pkg;

	localparam int BindSlotsDefault  = 8;
	localparam int ClientBitsDefault = 4;
	localparam int QueueDepth        = 4;

	localparam logic [15:0] HDR_BYTES = 16'd8;

	typedef enum logic [1:0] {
		OP_DATA   = 2'd0,
		OP_BIND   = 2'd1,
		OP_UNBIND = 2'd2
	} op_t;

	// Result of one datagram byte; the client id travels beside it.
	typedef struct packed {
		logic [31:0] sender_address;
		logic [15:0] sender_port;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
		logic        empty_payload;
		logic        run_last;
	} res_t;

	localparam int ResBits = $bits(res_t);

endpackage

### src/udp_port_demux.sv
// ----------------------------------------------------------------------------
// udp_port_demux
// Receive-side UDP port demultiplexer with a table of bound ports.
// ----------------------------------------------------------------------------
// The block takes one request every clock cycle while its result queue is not
// full: a bind, an unbind or one datagram byte. The front stage parses the
// header and compares the destination port against all table slots in
// parallel, and queues each result in a four-entry queue; the output register
// loads it from the queue once that register is empty or being read. Input
// ready falls only when that queue is full, so a stalled output side backs up
// after four results plus the one in the output register.
module udp_port_demux import udpd_pkg::*; #(
	parameter int BIND_SLOTS  = BindSlotsDefault,
	parameter int CLIENT_BITS = ClientBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bind_port, client_id, data_byte, datagram_length, source_address
	input  logic [((CLIENT_BITS + 72 + 7) / 8) * 8 - 1:0] s_tdata,
	// operation
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// target_client, sender_address, sender_port, payload_length, payload_byte
	output logic [((CLIENT_BITS + 72 + 7) / 8) * 8 - 1:0] m_tdata,
	// empty_payload
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int TD_W = ((CLIENT_BITS + 72 + 7) / 8) * 8;
	localparam int CO   = 16;
	localparam int BO   = CO + CLIENT_BITS;
	localparam int LO   = BO + 8;
	localparam int AO   = LO + 16;
	localparam int QW   = ResBits + CLIENT_BITS;

	logic                   q_full;
	logic                   push;
	res_t                   f_res;
	logic [CLIENT_BITS-1:0] f_client;
	logic                   pop;
	logic                   q_valid;
	logic [QW-1:0]          q_rdata;

	udpd_front #(
		.BIND_SLOTS (BIND_SLOTS),
		.CLIENT_BITS(CLIENT_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.operation      (s_tuser),
		.bind_port      (s_tdata[CO-1:0]),
		.client_id      (s_tdata[BO-1:CO]),
		.data_byte      (s_tdata[LO-1:BO]),
		.final_byte     (s_tlast),
		.datagram_length(s_tdata[AO-1:LO]),
		.source_address (s_tdata[AO+31:AO]),
		.q_full         (q_full),
		.push           (push),
		.res            (f_res),
		.res_client     (f_client)
	);

	udpd_fifo #(
		.WIDTH(QW),
		.DEPTH(QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    ({f_client, f_res}),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_valid),
		.rdata    (q_rdata)
	);

	udpd_back #(
		.CLIENT_BITS(CLIENT_BITS),
		.OUT_W      (TD_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_res   (res_t'(q_rdata[ResBits-1:0])),
		.q_client(q_rdata[QW-1:ResBits]),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

### src/udpd_front.sv
// ----------------------------------------------------------------------------
// udpd_front
// Port table and header parser: takes one request a cycle while the result queue is not full, and classifies it.
// ----------------------------------------------------------------------------
module udpd_front import udpd_pkg::*; #(
	parameter int BIND_SLOTS  = BindSlotsDefault,
	parameter int CLIENT_BITS = ClientBitsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  logic [15:0]            bind_port,
	input  logic [CLIENT_BITS-1:0] client_id,
	input  logic [7:0]             data_byte,
	input  logic                   final_byte,
	input  logic [15:0]            datagram_length,
	input  logic [31:0]            source_address,
	input  logic                   q_full,
	output logic                   push,
	output res_t                   res,
	output logic [CLIENT_BITS-1:0] res_client
);

	logic [BIND_SLOTS-1:0]  slot_valid_q;
	logic [15:0]            slot_port_q   [BIND_SLOTS];
	logic [CLIENT_BITS-1:0] slot_client_q [BIND_SLOTS];

	logic [15:0]            byte_idx_q;
	logic [15:0]            hdr_src_q;
	logic [15:0]            hdr_dst_q;
	logic [15:0]            hdr_len_q;
	logic [15:0]            lat_len_q;
	logic [31:0]            lat_addr_q;
	logic [CLIENT_BITS-1:0] match_client_q;
	logic                   accepting_q;

	logic                   accept;
	logic                   is_data;
	logic [BIND_SLOTS-1:0]  free_oh;
	logic [BIND_SLOTS-1:0]  unb_hits;
	logic [BIND_SLOTS-1:0]  unb_oh;
	logic [BIND_SLOTS-1:0]  dst_hits;
	logic [CLIENT_BITS-1:0] dst_client;
	logic                   len_ok;
	logic                   last_byte;
	logic                   accepting_d;
	logic [CLIENT_BITS-1:0] match_client_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < BIND_SLOTS; i++) begin
			unb_hits[i] = slot_valid_q[i] && (slot_port_q[i] == bind_port);
			dst_hits[i] = slot_valid_q[i] && (slot_port_q[i] == hdr_dst_q);
		end
	end

	// Lowest free slot and lowest matching slot, both one-hot.
	assign free_oh = ~slot_valid_q & (slot_valid_q + BIND_SLOTS'(1));
	assign unb_oh  = unb_hits & (~unb_hits + BIND_SLOTS'(1));

	always_comb begin
		dst_client = '0;
		for (int i = BIND_SLOTS - 1; i >= 0; i--) begin
			if (dst_hits[i]) begin
				dst_client = slot_client_q[i];
			end
		end
	end

	assign len_ok    = (hdr_len_q >= HDR_BYTES) && (hdr_len_q <= lat_len_q);
	assign last_byte = final_byte ||
		(({1'b0, byte_idx_q} + 17'd1) == {1'b0, hdr_len_q});

	always_comb begin
		is_data        = 1'b0;
		push           = 1'b0;
		accepting_d    = accepting_q;
		match_client_d = match_client_q;
		res_client     = match_client_q;
		res.sender_address = lat_addr_q;
		res.sender_port    = hdr_src_q;
		res.payload_length = hdr_len_q - HDR_BYTES;
		res.payload_byte   = data_byte;
		res.empty_payload  = 1'b0;
		res.run_last       = last_byte;
		case (op_t'(operation))
			OP_DATA: begin
				is_data = 1'b1;
			end
			default: begin
			end
		endcase
		if (is_data) begin
			if (byte_idx_q == '0) begin
				accepting_d = 1'b0;
			end else if (byte_idx_q == HDR_BYTES - 16'd1) begin
				accepting_d    = len_ok && (|dst_hits);
				match_client_d = dst_client;
				res_client     = dst_client;
				if (accepting_d && hdr_len_q == HDR_BYTES) begin
					push               = accept;
					res.payload_byte   = '0;
					res.empty_payload  = 1'b1;
					res.run_last       = 1'b1;
					accepting_d        = 1'b0;
				end
			end else if (byte_idx_q >= HDR_BYTES && accepting_q &&
					byte_idx_q < hdr_len_q) begin
				push = accept;
				if (last_byte) begin
					accepting_d = 1'b0;
				end
			end
			if (final_byte) begin
				accepting_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q   <= '0;
			byte_idx_q     <= '0;
			accepting_q    <= 1'b0;
			match_client_q <= '0;
		end else if (accept) begin
			case (op_t'(operation))
				OP_BIND: begin
					slot_valid_q <= slot_valid_q | free_oh;
				end
				OP_UNBIND: begin
					slot_valid_q <= slot_valid_q & ~unb_oh;
				end
				OP_DATA: begin
					accepting_q    <= accepting_d;
					match_client_q <= match_client_d;
					if (final_byte) begin
						byte_idx_q <= '0;
					end else if (byte_idx_q != '1) begin
						byte_idx_q <= byte_idx_q + 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op_t'(operation) == OP_BIND) begin
			for (int i = 0; i < BIND_SLOTS; i++) begin
				if (free_oh[i]) begin
					slot_port_q[i]   <= bind_port;
					slot_client_q[i] <= client_id;
				end
			end
		end
		if (accept && is_data) begin
			case (byte_idx_q)
				16'd0: begin
					lat_len_q  <= datagram_length;
					lat_addr_q <= source_address;
					hdr_src_q  <= {data_byte, 8'h00};
				end
				16'd1: begin
					hdr_src_q <= {hdr_src_q[15:8], data_byte};
				end
				16'd2: begin
					hdr_dst_q <= {data_byte, 8'h00};
				end
				16'd3: begin
					hdr_dst_q <= {hdr_dst_q[15:8], data_byte};
				end
				16'd4: begin
					hdr_len_q <= {data_byte, 8'h00};
				end
				16'd5: begin
					hdr_len_q <= {hdr_len_q[15:8], data_byte};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### src/udpd_fifo.sv
// ----------------------------------------------------------------------------
// udpd_fifo
// Short result queue between the classifying front and the output stage.
// ----------------------------------------------------------------------------
module udpd_fifo import udpd_pkg::*; #(
	parameter int WIDTH = ResBits,
	parameter int DEPTH = QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### src/udpd_back.sv
// ----------------------------------------------------------------------------
// udpd_back
// Output stage: pulls results from the queue and presents them on the stream.
// ----------------------------------------------------------------------------
module udpd_back import udpd_pkg::*; #(
	parameter int CLIENT_BITS = ClientBitsDefault,
	parameter int OUT_W       = ((CLIENT_BITS + 72 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  res_t                   q_res,
	input  logic [CLIENT_BITS-1:0] q_client,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	localparam int PAD = OUT_W - (CLIENT_BITS + 72);

	res_t                   res_q;
	logic [CLIENT_BITS-1:0] client_q;
	logic                   valid_q;

	// The output register refills in the same cycle that its result is taken, or whenever it is empty.
	assign pop = q_valid && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q    <= q_res;
			client_q <= q_client;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.empty_payload;
	assign m_tlast  = res_q.run_last;

	generate
		if (PAD > 0) begin : g_pad
			assign m_tdata = {{PAD{1'b0}}, res_q.payload_byte, res_q.payload_length,
				res_q.sender_port, res_q.sender_address, client_q};
		end else begin : g_nopad
			assign m_tdata = {res_q.payload_byte, res_q.payload_length,
				res_q.sender_port, res_q.sender_address, client_q};
		end
	endgenerate

endmodule

### src/udpd_chk.sv
// ----------------------------------------------------------------------------
// udpd_chk
// Port-level checks on the result stream of the UDP port demultiplexer.
// ----------------------------------------------------------------------------
module udpd_chk import udpd_pkg::*; #(
	parameter int CLIENT_BITS = ClientBitsDefault
) (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [((CLIENT_BITS + 72 + 7) / 8) * 8 - 1:0] m_tdata,
	input logic         m_tuser,
	input logic         m_tlast
);

	localparam int PL = CLIENT_BITS + 48;
	localparam int PB = PL + 16;

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// An empty datagram gives exactly one result, so it must close the run.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("empty result not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[PB+7:PB] == 8'd0 && m_tdata[PB-1:PL] == 16'd0)
		else $error("empty result carries payload");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[PB-1:PL] != 16'd0)
		else $error("payload byte with zero payload length");

endmodule

bind udp_port_demux udpd_chk #(.CLIENT_BITS(CLIENT_BITS)) u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
